FILE: rtl/core/rfw_pkg.sv
// ----------------------------------------------------------------------------
// rfw_pkg: shared types and constants of the radial falloff weight core
// Widths of the distance, divider and pipeline tag, and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package rfw_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 6;
  localparam int BASE_W   = 17;
  localparam int MDIST_W  = 16;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 2;

  // |offset| stays below 2^17, so each square fits 33 bits and the sum 34.
  localparam int ABS_W    = 17;
  localparam int SQ_W     = 33;
  localparam int SUM_W    = 34;
  // Radicand is sum * 65536; its root (distance in Q.8) has 25 bits.
  localparam int RAD_W    = SUM_W + 16;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int DIST_W   = ROOT_W + 1;
  // Divider numerator dist * 256 + max_dist / 2.
  localparam int NUM_W    = DIST_W + 8;
  localparam int QUO_W    = 16;
  localparam int SCALE_W  = 17;
  localparam int PROD_W   = SAMPLE_W + SCALE_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_DX  = 2'd0,
    REG_BASE_DY  = 2'd1,
    REG_BASE_DZ  = 2'd2,
    REG_MAX_DIST = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
  } pipe_tag_t;

endpackage
`default_nettype wire

FILE: rtl/core/rfw_sqrt.sv
// ----------------------------------------------------------------------------
// rfw_sqrt: pipelined round-to-nearest square root
// One root bit per stage, then one stage that rounds from the remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module rfw_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire rfw_pkg::pipe_tag_t           in_tag,
  input  wire logic [rfw_pkg::SUM_W-1:0]    in_sum,
  output rfw_pkg::pipe_tag_t                out_tag,
  output logic      [rfw_pkg::DIST_W-1:0]   out_dist
);
  import rfw_pkg::*;

  pipe_tag_t          tag_r  [ROOT_W];
  logic [REM_W-1:0]   rem_r  [ROOT_W];
  logic [ROOT_W-1:0]  root_r [ROOT_W];
  logic [RAD_W-1:0]   rad_r  [ROOT_W];
  pipe_tag_t          fin_tag_r;
  logic [DIST_W-1:0]  dist_r;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    pipe_tag_t         tag_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign tag_i  = in_tag;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = {in_sum, 16'h0000};
    end else begin : g_next
      assign tag_i  = tag_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
    end

    always_comb begin
      cur   = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
      trial = {1'b0, root_i, 2'b01};
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k].valid <= 1'b0;
      end else if (en) begin
        tag_r[k]  <= tag_i;
        rem_r[k]  <= ge ? (cur - trial) : cur;
        root_r[k] <= {root_i[ROOT_W-2:0], ge};
        rad_r[k]  <= {rad_i[RAD_W-3:0], 2'b00};
      end
    end
  end

  // Round up when the remainder v - r*r exceeds r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_tag_r.valid <= 1'b0;
    end else if (en) begin
      fin_tag_r <= tag_r[ROOT_W-1];
      dist_r    <= {1'b0, root_r[ROOT_W-1]} +
                   DIST_W'(rem_r[ROOT_W-1] > REM_W'(root_r[ROOT_W-1]));
    end
  end

  assign out_tag  = fin_tag_r;
  assign out_dist = dist_r;

endmodule
`default_nettype wire

FILE: rtl/core/rfw_div.sv
// ----------------------------------------------------------------------------
// rfw_div: pipelined restoring divider for the distance ratio
// Sixteen quotient bits, one per stage; overflow is flagged by the caller on in_sat.
// ----------------------------------------------------------------------------
`default_nettype none
module rfw_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire rfw_pkg::pipe_tag_t            in_tag,
  input  wire logic                          in_sat,
  input  wire logic [rfw_pkg::QUO_W-1:0]     in_rem,
  input  wire logic [rfw_pkg::QUO_W-1:0]     in_low,
  input  wire logic [rfw_pkg::MDIST_W-1:0]   max_dist,
  output rfw_pkg::pipe_tag_t                 out_tag,
  output logic                               out_sat,
  output logic      [rfw_pkg::QUO_W-1:0]     out_quo
);
  import rfw_pkg::*;

  pipe_tag_t         tag_r [QUO_W];
  logic              sat_r [QUO_W];
  logic [QUO_W-1:0]  rem_r [QUO_W];
  logic [QUO_W-1:0]  low_r [QUO_W];
  logic [QUO_W-1:0]  quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    pipe_tag_t        tag_i;
    logic             sat_i;
    logic [QUO_W-1:0] rem_i;
    logic [QUO_W-1:0] low_i;
    logic [QUO_W-1:0] quo_i;
    logic [QUO_W:0]   cur;
    logic             ge;

    if (k == 0) begin : g_first
      assign tag_i = in_tag;
      assign sat_i = in_sat;
      assign rem_i = in_rem;
      assign low_i = in_low;
      assign quo_i = '0;
    end else begin : g_next
      assign tag_i = tag_r[k-1];
      assign sat_i = sat_r[k-1];
      assign rem_i = rem_r[k-1];
      assign low_i = low_r[k-1];
      assign quo_i = quo_r[k-1];
    end

    always_comb begin
      cur = {rem_i, low_i[QUO_W-1]};
      ge  = (cur >= {1'b0, max_dist});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k].valid <= 1'b0;
      end else if (en) begin
        tag_r[k] <= tag_i;
        sat_r[k] <= sat_i;
        rem_r[k] <= ge ? QUO_W'(cur - {1'b0, max_dist}) : cur[QUO_W-1:0];
        low_r[k] <= {low_i[QUO_W-2:0], 1'b0};
        quo_r[k] <= {quo_i[QUO_W-2:0], ge};
      end
    end
  end

  assign out_tag = tag_r[QUO_W-1];
  assign out_sat = sat_r[QUO_W-1];
  assign out_quo = quo_r[QUO_W-1];

endmodule
`default_nettype wire

FILE: rtl/core/radial_falloff_weight_core.sv
// ----------------------------------------------------------------------------
// radial_falloff_weight_core: linear radial falloff weighting of voxel samples
// Scales each sample by max(0, 1 - dist / max_dist) around a sphere center.
// ----------------------------------------------------------------------------
// The core takes one sample per cycle unless its output is stalled, and
// computes its weighted value in these stages: three stages form the
// offsets, squares and their sum, the square root takes one stage per root
// bit plus a rounding stage (26), the ratio takes a setup stage and one
// stage per quotient bit (17), and scale and multiply take two more before
// the output register, which also rounds and saturates. The whole pipeline
// holds while a result is stalled at the output.
`default_nettype none
module radial_falloff_weight_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic        [rfw_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic        [rfw_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [rfw_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic        [rfw_pkg::POS_W-1:0]    in_x_pos,
  input  wire logic        [rfw_pkg::POS_W-1:0]    in_y_pos,
  input  wire logic        [rfw_pkg::POS_W-1:0]    in_z_pos,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed      [rfw_pkg::SAMPLE_W-1:0] out_weighted
);
  import rfw_pkg::*;

  logic signed [BASE_W-1:0]  base_dx_r, base_dy_r, base_dz_r;
  logic        [MDIST_W-1:0] max_dist_r;

  logic en;

  pipe_tag_t          a_tag_r;
  logic [ABS_W-1:0]   ax_r, ay_r, az_r;
  pipe_tag_t          b_tag_r;
  logic [SQ_W-1:0]    sx_r, sy_r, sz_r;
  pipe_tag_t          c_tag_r;
  logic [SUM_W-1:0]   sum_r;
  pipe_tag_t          sq_tag;
  logic [DIST_W-1:0]  root_dist;
  pipe_tag_t          d_tag_r;
  logic               d_sat_r;
  logic [NUM_W-1:0]   d_num_r;
  pipe_tag_t          dv_tag;
  logic               dv_sat;
  logic [QUO_W-1:0]   dv_quo;
  pipe_tag_t          e_tag_r;
  logic [SCALE_W-1:0] scale_r;
  pipe_tag_t          f_tag_r;
  logic signed [PROD_W-1:0] prod_r;
  logic               out_valid_r;
  logic signed [SAMPLE_W-1:0] weighted_r;

  logic [ABS_W-1:0]   ax_nxt, ay_nxt, az_nxt;
  logic [NUM_W-1:0]   num_nxt;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-17:0] q_full;
  logic signed [SAMPLE_W-1:0] weighted_nxt;

  function automatic logic [ABS_W-1:0] abs_offset(logic signed [BASE_W-1:0] base,
                                                   logic [POS_W-1:0] pos);
    logic signed [BASE_W:0] d;
    d = {base[BASE_W-1], base} + $signed({{(BASE_W+1-POS_W){1'b0}}, pos});
    return d[BASE_W] ? ABS_W'(-d) : ABS_W'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_dx_r  <= '0;
      base_dy_r  <= '0;
      base_dz_r  <= '0;
      max_dist_r <= MDIST_W'(100);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BASE_DX:  base_dx_r  <= cfg_wdata;
        REG_BASE_DY:  base_dy_r  <= cfg_wdata;
        REG_BASE_DZ:  base_dz_r  <= cfg_wdata;
        REG_MAX_DIST: max_dist_r <= cfg_wdata[MDIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_comb begin
    ax_nxt = abs_offset(base_dx_r, in_x_pos);
    ay_nxt = abs_offset(base_dy_r, in_y_pos);
    az_nxt = abs_offset(base_dz_r, in_z_pos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r.valid <= 1'b0;
      b_tag_r.valid <= 1'b0;
      c_tag_r.valid <= 1'b0;
    end else if (en) begin
      a_tag_r <= '{valid: in_valid, sample: in_sample};
      ax_r    <= ax_nxt;
      ay_r    <= ay_nxt;
      az_r    <= az_nxt;
      b_tag_r <= a_tag_r;
      sx_r    <= SQ_W'(ax_r * ax_r);
      sy_r    <= SQ_W'(ay_r * ay_r);
      sz_r    <= SQ_W'(az_r * az_r);
      c_tag_r <= b_tag_r;
      sum_r   <= SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r);
    end
  end

  rfw_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_tag   (c_tag_r),
    .in_sum   (sum_r),
    .out_tag  (sq_tag),
    .out_dist (root_dist)
  );

  assign num_nxt = {root_dist, 8'h00} + NUM_W'(max_dist_r >> 1);

  // A ratio of 1.0 or more (and a zero radius) gives weight zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_tag_r.valid <= 1'b0;
    end else if (en) begin
      d_tag_r <= sq_tag;
      d_num_r <= num_nxt;
      d_sat_r <= (num_nxt[NUM_W-1:QUO_W] >= (NUM_W-QUO_W)'(max_dist_r));
    end
  end

  rfw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_tag   (d_tag_r),
    .in_sat   (d_sat_r),
    .in_rem   (QUO_W'(d_num_r[NUM_W-1:QUO_W])),
    .in_low   (d_num_r[QUO_W-1:0]),
    .max_dist (max_dist_r),
    .out_tag  (dv_tag),
    .out_sat  (dv_sat),
    .out_quo  (dv_quo)
  );

  always_comb begin
    rnd    = prod_r + PROD_W'(32768);
    q_full = rnd[PROD_W-1:16];
    if (q_full > $signed((PROD_W-16)'(32767))) begin
      weighted_nxt = 16'sh7FFF;
    end else if (q_full < -$signed((PROD_W-16)'(32768))) begin
      weighted_nxt = -16'sh8000;
    end else begin
      weighted_nxt = q_full[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_tag_r.valid <= 1'b0;
      f_tag_r.valid <= 1'b0;
      out_valid_r   <= 1'b0;
    end else if (en) begin
      e_tag_r     <= dv_tag;
      scale_r     <= dv_sat ? '0 : (SCALE_W'(1) << QUO_W) - SCALE_W'(dv_quo);
      f_tag_r     <= e_tag_r;
      prod_r      <= PROD_W'(e_tag_r.sample) * $signed({1'b0, scale_r});
      out_valid_r <= f_tag_r.valid;
      weighted_r  <= weighted_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_weighted = weighted_r;

  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    e_tag_r.valid |-> (scale_r <= (SCALE_W'(1) << QUO_W)))
    else $error("scale above one");

  a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en && dv_tag.valid && dv_sat) |=> (scale_r == '0))
    else $error("saturated ratio did not give zero weight");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> in_stall)
    else $error("input accepted while output is stalled");

  a_valid_travel: assert property (@(posedge clk) disable iff (!rst_n)
    (en && f_tag_r.valid) |=> out_valid_r)
    else $error("valid lost at output stage");

endmodule
`default_nettype wire

FILE: dv/radial_falloff_weight_checker.sv
// ----------------------------------------------------------------------------
// radial_falloff_weight_checker: scoreboard of the radial falloff weight core
// Mirrors the configuration registers, computes the weighted sample of every
// accepted input transaction and compares each accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none
module radial_falloff_weight_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic        [rfw_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic        [rfw_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic signed [rfw_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic        [rfw_pkg::POS_W-1:0]    in_x_pos,
  input  wire logic        [rfw_pkg::POS_W-1:0]    in_y_pos,
  input  wire logic        [rfw_pkg::POS_W-1:0]    in_z_pos,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic signed [rfw_pkg::SAMPLE_W-1:0] out_weighted,
  output int                                       fail_count,
  output int                                       pending_count
);
  import rfw_pkg::*;

  logic signed [BASE_W-1:0]   off_x, off_y, off_z;
  logic        [MDIST_W-1:0]  radius;
  logic signed [SAMPLE_W-1:0] weighted_q[$];

  assign pending_count = weighted_q.size();

  function automatic longint unsigned root_nearest(longint unsigned v);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    // v now holds the remainder of the floor root.
    if (v > r) r += 1;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] weigh_sample(
      logic signed [SAMPLE_W-1:0] s, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
      logic [POS_W-1:0] z);
    longint dx, dy, dz, p, t, q;
    longint unsigned sum, root_q8, ratio, scale;
    dx = longint'(off_x) + longint'(x);
    dy = longint'(off_y) + longint'(y);
    dz = longint'(off_z) + longint'(z);
    sum = dx * dx + dy * dy + dz * dz;
    root_q8 = root_nearest(sum << 16);
    scale = 0;
    if (radius != 0) begin
      ratio = (root_q8 * 256 + radius / 2) / radius;
      if (ratio < 65536) scale = 65536 - ratio;
    end
    p = longint'(s) * longint'(scale);
    t = p + 32768;
    q = (t >= 0) ? t / 65536 : -((-t + 65535) / 65536);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SAMPLE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
      radius <= 16'd100;
      fail_count <= 0;
      weighted_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_idx))
          REG_BASE_DX:  off_x <= cfg_wdata;
          REG_BASE_DY:  off_y <= cfg_wdata;
          REG_BASE_DZ:  off_z <= cfg_wdata;
          REG_MAX_DIST: radius <= cfg_wdata[MDIST_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        weighted_q.insert(weighted_q.size(),
                          weigh_sample(in_sample, in_x_pos, in_y_pos, in_z_pos));
      if (out_valid && !out_stall) begin
        if (weighted_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time,
                   out_weighted);
          fail_count <= fail_count + 1;
        end else begin
          if (out_weighted !== weighted_q[0]) begin
            $display("%0t: weighted mismatch, expected %0d, actual %0d", $time,
                     weighted_q[0], out_weighted);
            fail_count <= fail_count + 1;
          end
          void'(weighted_q.pop_front());
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: dv/tb_radial_falloff_weight_core.sv
// ----------------------------------------------------------------------------
// tb_radial_falloff_weight_core: testbench of the radial falloff weight core
// Drives directed and random voxel samples under several offset and radius
// settings with random gaps and output stalls; a checker scores the results.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_radial_falloff_weight_core;
  import rfw_pkg::*;

  localparam int LATENCY = 50;
  localparam int CYCLE_LIMIT = 400000;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic        [CFG_IDX_W-1:0]  cfg_idx;
  logic        [CFG_W-1:0]      cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [SAMPLE_W-1:0]   in_sample;
  logic        [POS_W-1:0]      in_x_pos, in_y_pos, in_z_pos;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [SAMPLE_W-1:0]   out_weighted;
  int                           fail_count;
  int                           pending_count;
  int                           cycle_count = 0;
  bit                           stall_enable;

  radial_falloff_weight_core u_dut (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .in_valid, .in_stall, .in_sample, .in_x_pos, .in_y_pos, .in_z_pos,
    .out_valid, .out_stall, .out_weighted
  );

  radial_falloff_weight_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .in_valid, .in_stall, .in_sample, .in_x_pos, .in_y_pos, .in_z_pos,
    .out_valid, .out_stall, .out_weighted, .fail_count, .pending_count
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stalls: a random hold after every result while stalls are enabled.
  initial begin : stall_gen
    int n;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      @(negedge clk);
      if (!stall_enable) begin
        out_stall <= 1'b0;
      end else begin
        n = $urandom_range(0, 4);
        if (n == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat (n - 1) @(negedge clk);
          out_stall <= 1'b0;
        end
        @(posedge clk iff out_valid);
      end
    end
  end

  task automatic write_reg(cfg_reg_e r, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(int bx, int by, int bz, int rad);
    write_reg(REG_BASE_DX, bx[CFG_W-1:0]);
    write_reg(REG_BASE_DY, by[CFG_W-1:0]);
    write_reg(REG_BASE_DZ, bz[CFG_W-1:0]);
    write_reg(REG_MAX_DIST, rad[CFG_W-1:0]);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // Sends one voxel transaction after a random gap; gaps may be disabled.
  task automatic send_voxel(logic [SAMPLE_W-1:0] s, logic [POS_W-1:0] x,
                            logic [POS_W-1:0] y, logic [POS_W-1:0] z, bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 4) : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_x_pos <= x;
    in_y_pos <= y;
    in_z_pos <= z;
    @(posedge clk iff !in_stall);
    @(negedge clk);
  endtask

  task automatic random_voxels(int count);
    bit gaps;
    logic [SAMPLE_W-1:0] s;
    gaps = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        gaps = $urandom_range(0, 2) != 0;
        stall_enable = $urandom_range(0, 2) != 0;
      end
      case ($urandom_range(0, 5))
        0: s = 16'h8000;
        1: s = 16'h7fff;
        default: s = SAMPLE_W'($urandom());
      endcase
      send_voxel(s, POS_W'($urandom()), POS_W'($urandom()), POS_W'($urandom()), gaps);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    stall_enable = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_sample = '0;
    in_x_pos = '0;
    in_y_pos = '0;
    in_z_pos = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, extremes of sample and grid corners.
    send_voxel(16'h7fff, 0, 0, 0, 1'b0);
    send_voxel(16'h8000, 0, 0, 0, 1'b0);
    send_voxel(16'h0000, 63, 63, 63, 1'b0);
    send_voxel(16'h8000, 63, 63, 63, 1'b1);
    send_voxel(16'h7fff, 57, 0, 0, 1'b1);
    send_voxel(16'h8000, 0, 58, 0, 1'b1);
    send_voxel(16'hffff, 0, 0, 59, 1'b1);
    send_voxel(16'h0001, 20, 30, 40, 1'b1);
    send_voxel(16'h5555, 42, 21, 0, 1'b1);
    send_voxel(16'haaaa, 21, 42, 63, 1'b1);
    in_valid <= 1'b0;
    // The sender holds off until every outstanding result has come back.
    drain();

    // Zero radius: every weight is zero.
    set_geometry(-32, -32, -32, 0);
    send_voxel(16'h7fff, 32, 32, 32, 1'b0);
    send_voxel(16'h8000, 0, 63, 17, 1'b1);
    random_voxels(40);
    drain();

    // Most negative offsets and the largest radius.
    set_geometry(-65536, -65536, -65536, 65535);
    send_voxel(16'h7fff, 0, 0, 0, 1'b0);
    send_voxel(16'h8000, 63, 63, 63, 1'b1);
    random_voxels(150);
    drain();

    // Most positive offsets with a radius of one voxel.
    set_geometry(65535, 65535, 65535, 1);
    send_voxel(16'h7fff, 63, 63, 63, 1'b0);
    random_voxels(100);
    drain();

    // Unit radius at the center: only the center voxel keeps weight.
    set_geometry(-1, 0, -1, 1);
    send_voxel(16'h7fff, 1, 0, 1, 1'b0);
    send_voxel(16'h8000, 1, 0, 1, 1'b1);
    random_voxels(100);
    drain();

    // Random settings with the center inside or near the chunk.
    for (int k = 0; k < 10; k++) begin
      set_geometry(-$urandom_range(0, 80), -$urandom_range(0, 80),
                   -$urandom_range(0, 80), $urandom_range(1, 120));
      random_voxels(100);
      drain();
    end
    set_geometry($urandom_range(0, 131071) - 65536, $urandom_range(0, 131071) - 65536,
                 $urandom_range(0, 131071) - 65536, $urandom());
    random_voxels(40);
    drain();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/rfw_pkg.sv
rtl/core/rfw_sqrt.sv
rtl/core/rfw_div.sv
rtl/core/radial_falloff_weight_core.sv
dv/radial_falloff_weight_checker.sv
dv/tb_radial_falloff_weight_core.sv
